[rtl/tbp_pkg.sv]
package tbp_pkg;

   // Default geometry
   localparam int TABLE_ENTRIES_DEF       = 1024;
   localparam int LOCAL_HISTORY_BITS_DEF  = 3;
   localparam int GLOBAL_HISTORY_BITS_DEF = 10;

   // Fixed field widths
   localparam int PC_W  = 32;
   localparam int CTR_W = 2;

   localparam logic [CTR_W-1:0] CTR_MAX       = 2'd3;
   localparam logic [CTR_W-1:0] CTR_MIN       = 2'd0;
   localparam logic [CTR_W-1:0] CTR_RESET     = 2'd3;
   localparam logic [CTR_W-1:0] CTR_TAKEN_MIN = 2'd2;

   typedef enum logic [1:0] {
      MODE_ALWAYS     = 2'd0,
      MODE_LOCAL      = 2'd1,
      MODE_GSHARE     = 2'd2,
      MODE_TOURNAMENT = 2'd3
   } mode_type;

   localparam mode_type MODE_RESET = MODE_TOURNAMENT;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INDEX,
      ST_UPDATE
   } state_type;

   // Table port control
   typedef struct packed {
      logic rd_en;
      logic wr_entry;
      logic wr_gshare;
   } tbl_ctrl_type;

   // Which sides train on this branch
   typedef struct packed {
      logic train_local;
      logic train_gshare;
   } train_type;

   // Saturating 2-bit counter step
   function automatic logic [CTR_W-1:0] sat_move(input logic [CTR_W-1:0] c, input logic up);
      logic [CTR_W-1:0] r;
      r = c;
      if (up) begin
         if (c != CTR_MAX) r = c + CTR_W'(1);
      end else begin
         if (c != CTR_MIN) r = c - CTR_W'(1);
      end
      return r;
   endfunction

endpackage

[rtl/tbp_if.sv]
// Branch request channel
interface tbp_req_if import tbp_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [PC_W-1:0] branch_pc;
   logic            branch_taken;

   modport source (output valid, output branch_pc, output branch_taken, input ready);
   modport sink   (input valid, input branch_pc, input branch_taken, output ready);
endinterface

// Prediction result channel
interface tbp_rsp_if import tbp_pkg::*; ();
   logic valid;
   logic ready;
   logic predicted_taken;
   logic prediction_correct;
   logic used_global;

   modport source (output valid, output predicted_taken, output prediction_correct,
                   output used_global, input ready);
   modport sink   (input valid, input predicted_taken, input prediction_correct,
                   input used_global, output ready);
endinterface

[rtl/tbp_index_unit.sv]
module tbp_index_unit import tbp_pkg::*; #(
   parameter int TABLE_ENTRIES       = TABLE_ENTRIES_DEF,
   parameter int GLOBAL_HISTORY_BITS = GLOBAL_HISTORY_BITS_DEF,
   localparam int IDX_W              = $clog2(TABLE_ENTRIES)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [PC_W-1:0]                pc,
   input  logic [GLOBAL_HISTORY_BITS-1:0] ghist,
   output logic                           done,
   output logic [IDX_W-1:0]               entry_idx,
   output logic [IDX_W-1:0]               gshare_idx
);

   localparam bit IS_POW2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;

   logic [PC_W-1:0] hashed;

   assign hashed = pc ^ PC_W'(ghist);

   generate
      if (IS_POW2) begin : g_mask
         // Power-of-two table: modulo is the low bits
         logic [IDX_W-1:0] entry_ff;
         logic [IDX_W-1:0] gshare_ff;
         logic             done_ff;

         always_ff @(posedge clock) begin
            if (start) begin
               entry_ff  <= pc[IDX_W-1:0];
               gshare_ff <= hashed[IDX_W-1:0];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               done_ff <= 1'b0;
            end else begin
               done_ff <= start;
            end
         end

         assign done       = done_ff;
         assign entry_idx  = entry_ff;
         assign gshare_idx = gshare_ff;
      end else begin : g_recip
         // Remainder by reciprocal multiply: the quotient estimate is low by at
         // most one, so one conditional subtract finishes it; two lanes
         localparam int Q_W = PC_W - IDX_W + 1;
         localparam int P_W = 2 * PC_W + 1;
         localparam int M_W = Q_W + IDX_W + 1;
         localparam logic [IDX_W:0] MODULUS = (IDX_W + 1)'(TABLE_ENTRIES);
         localparam logic [63:0] RECIP_FULL =
            (64'd1 << (PC_W + IDX_W)) / 64'(TABLE_ENTRIES);
         localparam logic [PC_W:0] RECIP = RECIP_FULL[PC_W:0];

         logic [PC_W-1:0]  a_ff;
         logic [PC_W-1:0]  b_ff;
         logic [Q_W-1:0]   qa_ff;
         logic [Q_W-1:0]   qb_ff;
         logic [IDX_W:0]   ra_ff;
         logic [IDX_W:0]   rb_ff;
         logic [IDX_W-1:0] entry_ff;
         logic [IDX_W-1:0] gshare_ff;
         logic [3:0]       stage_ff;
         logic [P_W-1:0]   prod_a;
         logic [P_W-1:0]   prod_b;
         logic [M_W-1:0]   qm_a;
         logic [M_W-1:0]   qm_b;

         function automatic logic [IDX_W-1:0] fold(input logic [IDX_W:0] r);
            logic [IDX_W:0] t;
            t = r;
            if (r >= MODULUS) t = r - MODULUS;
            return t[IDX_W-1:0];
         endfunction

         assign prod_a = P_W'(a_ff) * P_W'(RECIP);
         assign prod_b = P_W'(b_ff) * P_W'(RECIP);
         assign qm_a   = M_W'(qa_ff) * M_W'(MODULUS);
         assign qm_b   = M_W'(qb_ff) * M_W'(MODULUS);

         // Quotient estimate, raw remainder, final correction
         always_ff @(posedge clock) begin
            if (start) begin
               a_ff <= pc;
               b_ff <= hashed;
            end
            qa_ff     <= prod_a[PC_W + IDX_W +: Q_W];
            qb_ff     <= prod_b[PC_W + IDX_W +: Q_W];
            ra_ff     <= a_ff[IDX_W:0] - qm_a[IDX_W:0];
            rb_ff     <= b_ff[IDX_W:0] - qm_b[IDX_W:0];
            entry_ff  <= fold(ra_ff);
            gshare_ff <= fold(rb_ff);
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               stage_ff <= '0;
            end else begin
               stage_ff <= {stage_ff[2:0], start};
            end
         end

         assign done       = stage_ff[3];
         assign entry_idx  = entry_ff;
         assign gshare_idx = gshare_ff;
      end
   endgenerate

endmodule

[rtl/tbp_tables.sv]
module tbp_tables import tbp_pkg::*; #(
   parameter int TABLE_ENTRIES      = TABLE_ENTRIES_DEF,
   parameter int LOCAL_HISTORY_BITS = LOCAL_HISTORY_BITS_DEF,
   localparam int IDX_W             = $clog2(TABLE_ENTRIES),
   localparam int CNT_BITS          = CTR_W << LOCAL_HISTORY_BITS,
   localparam int ROW_W             = CTR_W + LOCAL_HISTORY_BITS + CNT_BITS
) (
   input  logic              clock,
   input  logic              reset,
   input  tbl_ctrl_type      ctrl,
   input  logic [IDX_W-1:0]  entry_addr,
   input  logic [IDX_W-1:0]  gshare_addr,
   input  logic [ROW_W-1:0]  entry_wdata,
   input  logic [CTR_W-1:0]  gshare_wdata,
   output logic [ROW_W-1:0]  entry_rdata,
   output logic [CTR_W-1:0]  gshare_rdata,
   output logic              clear_busy
);

   // Row: chooser | local history | local counters
   localparam logic [ROW_W-1:0] ROW_RESET =
      {CTR_RESET, LOCAL_HISTORY_BITS'(0), {(1 << LOCAL_HISTORY_BITS){CTR_RESET}}};

   logic [ROW_W-1:0] entry_mem  [TABLE_ENTRIES];
   logic [CTR_W-1:0] gshare_mem [TABLE_ENTRIES];

   logic [ROW_W-1:0] entry_rd_ff;
   logic [CTR_W-1:0] gshare_rd_ff;
   logic [IDX_W-1:0] clr_idx_ff;
   logic             clr_busy_ff;

   logic             entry_we;
   logic             gshare_we;
   logic [IDX_W-1:0] entry_waddr;
   logic [IDX_W-1:0] gshare_waddr;
   logic [ROW_W-1:0] entry_wd;
   logic [CTR_W-1:0] gshare_wd;

   // Clearing sweep takes over the write port after reset
   always_comb begin
      entry_we     = clr_busy_ff || ctrl.wr_entry;
      gshare_we    = clr_busy_ff || ctrl.wr_gshare;
      entry_waddr  = clr_busy_ff ? clr_idx_ff : entry_addr;
      gshare_waddr = clr_busy_ff ? clr_idx_ff : gshare_addr;
      entry_wd     = clr_busy_ff ? ROW_RESET : entry_wdata;
      gshare_wd    = clr_busy_ff ? CTR_RESET : gshare_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_idx_ff <= clr_idx_ff + IDX_W'(1);
         if (clr_idx_ff == IDX_W'(TABLE_ENTRIES - 1)) clr_busy_ff <= 1'b0;
      end
   end

   // Entry memory
   always_ff @(posedge clock) begin
      if (entry_we) entry_mem[entry_waddr] <= entry_wd;
      if (ctrl.rd_en) entry_rd_ff <= entry_mem[entry_addr];
   end

   // Gshare memory
   always_ff @(posedge clock) begin
      if (gshare_we) gshare_mem[gshare_waddr] <= gshare_wd;
      if (ctrl.rd_en) gshare_rd_ff <= gshare_mem[gshare_addr];
   end

   assign entry_rdata  = entry_rd_ff;
   assign gshare_rdata = gshare_rd_ff;
   assign clear_busy   = clr_busy_ff;

endmodule

[rtl/tbp_train.sv]
module tbp_train import tbp_pkg::*; #(
   parameter int LOCAL_HISTORY_BITS  = LOCAL_HISTORY_BITS_DEF,
   parameter int GLOBAL_HISTORY_BITS = GLOBAL_HISTORY_BITS_DEF,
   localparam int CNT_BITS           = CTR_W << LOCAL_HISTORY_BITS,
   localparam int ROW_W              = CTR_W + LOCAL_HISTORY_BITS + CNT_BITS
) (
   input  mode_type                       mode,
   input  logic                           taken,
   input  logic [ROW_W-1:0]               row,
   input  logic [CTR_W-1:0]               gshare_ctr,
   input  logic [GLOBAL_HISTORY_BITS-1:0] ghist,
   output logic                           predicted_taken,
   output logic                           prediction_correct,
   output logic                           used_global,
   output train_type                      train,
   output logic [ROW_W-1:0]               new_row,
   output logic [CTR_W-1:0]               new_gshare_ctr,
   output logic [GLOBAL_HISTORY_BITS-1:0] new_ghist
);

   logic [CNT_BITS-1:0]           counters;
   logic [CNT_BITS-1:0]           new_counters;
   logic [LOCAL_HISTORY_BITS-1:0] hist;
   logic [LOCAL_HISTORY_BITS-1:0] new_hist;
   logic [CTR_W-1:0]              chooser;
   logic [CTR_W-1:0]              new_chooser;
   logic [CTR_W-1:0]              local_ctr;
   logic [LOCAL_HISTORY_BITS:0]   ctr_sel;
   logic                          local_pred;
   logic                          gshare_pred;
   logic                          choose_global;
   logic                          local_ok;
   logic                          gshare_ok;

   // Unpack the entry row
   assign counters = row[CNT_BITS-1:0];
   assign hist     = row[CNT_BITS +: LOCAL_HISTORY_BITS];
   assign chooser  = row[CNT_BITS + LOCAL_HISTORY_BITS +: CTR_W];
   assign ctr_sel  = {hist, 1'b0};
   assign local_ctr = counters[ctr_sel +: CTR_W];

   assign local_pred    = local_ctr >= CTR_TAKEN_MIN;
   assign gshare_pred   = gshare_ctr >= CTR_TAKEN_MIN;
   assign choose_global = chooser >= CTR_TAKEN_MIN;
   assign local_ok      = local_pred == taken;
   assign gshare_ok     = gshare_pred == taken;

   // Prediction select by mode
   always_comb begin
      unique case (mode)
         MODE_ALWAYS: begin
            predicted_taken = 1'b1;
            used_global     = 1'b0;
            train           = '{train_local: 1'b0, train_gshare: 1'b0};
         end
         MODE_LOCAL: begin
            predicted_taken = local_pred;
            used_global     = 1'b0;
            train           = '{train_local: 1'b1, train_gshare: 1'b0};
         end
         MODE_GSHARE: begin
            predicted_taken = gshare_pred;
            used_global     = 1'b1;
            train           = '{train_local: 1'b0, train_gshare: 1'b1};
         end
         MODE_TOURNAMENT: begin
            predicted_taken = choose_global ? gshare_pred : local_pred;
            used_global     = choose_global;
            train           = '{train_local: 1'b1, train_gshare: 1'b1};
         end
         default: begin
            predicted_taken = 1'b1;
            used_global     = 1'b0;
            train           = '{train_local: 1'b0, train_gshare: 1'b0};
         end
      endcase
   end

   assign prediction_correct = predicted_taken == taken;

   // Chooser moves toward the side that alone was right
   always_comb begin
      new_chooser = chooser;
      if (mode == MODE_TOURNAMENT && local_ok != gshare_ok) begin
         new_chooser = sat_move(chooser, gshare_ok);
      end
   end

   // Local counter and history update
   always_comb begin
      new_counters = counters;
      new_counters[ctr_sel +: CTR_W] = sat_move(local_ctr, taken);
   end

   assign new_hist       = LOCAL_HISTORY_BITS'({hist, taken});
   assign new_row        = {new_chooser, new_hist, new_counters};
   assign new_gshare_ctr = sat_move(gshare_ctr, taken);
   assign new_ghist      = GLOBAL_HISTORY_BITS'({ghist, taken});

endmodule

[rtl/tournament_branch_predictor.sv]
// Flow: a request transfer starts the index step, then the memory read and the
//   write-back step, which also loads the response register; table sizes other
//   than a power of two use a reciprocal remainder in the index step. A new
//   branch waits for the last write-back; a held response stalls the write-back.
// Reset: synchronous, active high; mode returns to tournament, global history
//   clears, then a clearing pass writes all TABLE_ENTRIES table rows.
module tournament_branch_predictor import tbp_pkg::*; #(
   parameter int TABLE_ENTRIES       = TABLE_ENTRIES_DEF,
   parameter int LOCAL_HISTORY_BITS  = LOCAL_HISTORY_BITS_DEF,
   parameter int GLOBAL_HISTORY_BITS = GLOBAL_HISTORY_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [1:0]       csr_wr_data,
   tbp_req_if.sink          req_chan,
   tbp_rsp_if.source        rsp_chan
);

   localparam int IDX_W    = $clog2(TABLE_ENTRIES);
   localparam int CNT_BITS = CTR_W << LOCAL_HISTORY_BITS;
   localparam int ROW_W    = CTR_W + LOCAL_HISTORY_BITS + CNT_BITS;

   state_type                      state_ff, state_in;
   mode_type                       mode_ff;
   logic [GLOBAL_HISTORY_BITS-1:0] ghist_ff, ghist_in;
   logic                           taken_ff;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           pred_ff;
   logic                           correct_ff;
   logic                           used_ff;

   logic             req_ready;
   logic             accept;
   logic             out_free;
   logic             upd_go;
   logic             idx_done;
   logic             clear_busy;
   logic [IDX_W-1:0] entry_idx;
   logic [IDX_W-1:0] gshare_idx;
   tbl_ctrl_type     tbl_ctrl;

   logic [ROW_W-1:0] entry_rdata;
   logic [CTR_W-1:0] gshare_rdata;
   logic [ROW_W-1:0] new_row;
   logic [CTR_W-1:0] new_gshare_ctr;
   logic [GLOBAL_HISTORY_BITS-1:0] new_ghist;
   logic             pred;
   logic             correct;
   logic             used_global;
   train_type        train;

   assign accept   = req_chan.valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_INDEX;
         ST_INDEX:  if (idx_done) state_in = ST_UPDATE;
         ST_UPDATE: if (out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_ready = 1'b0;
      upd_go    = 1'b0;
      tbl_ctrl  = '0;
      unique case (state_ff)
         ST_IDLE:   req_ready = !clear_busy;
         ST_INDEX:  tbl_ctrl.rd_en = idx_done;
         ST_UPDATE: begin
            upd_go             = out_free;
            tbl_ctrl.wr_entry  = out_free && train.train_local;
            tbl_ctrl.wr_gshare = out_free && train.train_gshare;
         end
         default: req_ready = 1'b0;
      endcase
   end

   assign req_chan.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_RESET;
      end else if (csr_wr_en) begin
         mode_ff <= mode_type'(csr_wr_data);
      end
   end

   // Global history
   always_comb begin
      ghist_in = ghist_ff;
      if (upd_go && train.train_gshare) ghist_in = new_ghist;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ghist_ff <= '0;
      end else begin
         ghist_ff <= ghist_in;
      end
   end

   // Outcome held for the update step
   always_ff @(posedge clock) begin
      if (accept) taken_ff <= req_chan.branch_taken;
   end

   tbp_index_unit #(
      .TABLE_ENTRIES       (TABLE_ENTRIES),
      .GLOBAL_HISTORY_BITS (GLOBAL_HISTORY_BITS)
   ) u_index (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .pc         (req_chan.branch_pc),
      .ghist      (ghist_ff),
      .done       (idx_done),
      .entry_idx  (entry_idx),
      .gshare_idx (gshare_idx)
   );

   tbp_tables #(
      .TABLE_ENTRIES      (TABLE_ENTRIES),
      .LOCAL_HISTORY_BITS (LOCAL_HISTORY_BITS)
   ) u_tables (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (tbl_ctrl),
      .entry_addr   (entry_idx),
      .gshare_addr  (gshare_idx),
      .entry_wdata  (new_row),
      .gshare_wdata (new_gshare_ctr),
      .entry_rdata  (entry_rdata),
      .gshare_rdata (gshare_rdata),
      .clear_busy   (clear_busy)
   );

   tbp_train #(
      .LOCAL_HISTORY_BITS  (LOCAL_HISTORY_BITS),
      .GLOBAL_HISTORY_BITS (GLOBAL_HISTORY_BITS)
   ) u_train (
      .mode               (mode_ff),
      .taken              (taken_ff),
      .row                (entry_rdata),
      .gshare_ctr         (gshare_rdata),
      .ghist              (ghist_ff),
      .predicted_taken    (pred),
      .prediction_correct (correct),
      .used_global        (used_global),
      .train              (train),
      .new_row            (new_row),
      .new_gshare_ctr     (new_gshare_ctr),
      .new_ghist          (new_ghist)
   );

   // Response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (upd_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd_go) begin
         pred_ff    <= pred;
         correct_ff <= correct;
         used_ff    <= used_global;
      end
   end

   assign rsp_chan.valid              = rsp_valid_ff;
   assign rsp_chan.predicted_taken    = pred_ff;
   assign rsp_chan.prediction_correct = correct_ff;
   assign rsp_chan.used_global        = used_ff;

   // No branch transfer while the tables are being cleared
   a_no_req_in_clear: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !req_chan.ready)
      else $error("request ready during table clear");

   // Index result arrives only while waiting for it
   a_idx_done_in_index: assert property (@(posedge clock) disable iff (reset)
      idx_done |-> state_ff == ST_INDEX)
      else $error("index done outside index state");

   // A new response only comes from an update step
   a_rsp_from_update: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_UPDATE)
      else $error("response valid without update");

   // Global history moves only on an update step
   a_ghist_update: assert property (@(posedge clock) disable iff (reset)
      !$stable(ghist_ff) |-> $past(state_ff) == ST_UPDATE)
      else $error("global history changed outside update");

endmodule

[verif/tournament_branch_predictor_test.sv]
module tournament_branch_predictor_test;
   import tbp_pkg::*;

   localparam int ENTRY_W       = $clog2(TABLE_ENTRIES_DEF);
   localparam int LHIST_W       = LOCAL_HISTORY_BITS_DEF;
   localparam int GHIST_W       = GLOBAL_HISTORY_BITS_DEF;
   localparam int LOCAL_CTRS    = TABLE_ENTRIES_DEF << LHIST_W;
   localparam int RANDOM_ITEMS  = 2000;
   localparam int POOL_SIZE     = 12;
   localparam int HOLD_AT       = 80;
   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 20;
   localparam int STALL_LIMIT   = 4000;
   localparam int SENDER        = 0;
   localparam int RECEIVER      = 1;

   // Field order matches the response payload
   typedef struct packed {
      logic predicted_taken;
      logic prediction_correct;
      logic used_global;
   } verdict_type;

   typedef struct packed {
      mode_type        mode;
      logic [PC_W-1:0] pc;
      logic            taken;
      logic            has_answer;
      verdict_type     answer;
   } branch_row_type;

   // Directed rows; answer is {predicted, correct, global} where has_answer is set
   localparam branch_row_type DIRECTED [24] = '{
      '{MODE_TOURNAMENT, 32'h0000_0000, 1'b1, 1'b1, 3'b111},  // fresh tables, all taken
      '{MODE_TOURNAMENT, 32'hFFFF_FFFF, 1'b0, 1'b1, 3'b101},  // fresh entry, mispredict
      '{MODE_TOURNAMENT, 32'hFFFF_FFFF, 1'b0, 1'b0, 3'b000},
      '{MODE_TOURNAMENT, 32'hFFFF_FFFF, 1'b0, 1'b0, 3'b000},
      '{MODE_TOURNAMENT, 32'h0000_0400, 1'b0, 1'b0, 3'b000},  // aliases entry 0
      '{MODE_TOURNAMENT, 32'h5555_5555, 1'b1, 1'b0, 3'b000},
      '{MODE_TOURNAMENT, 32'hAAAA_AAAA, 1'b0, 1'b0, 3'b000},
      '{MODE_ALWAYS,     32'hAAAA_AAAA, 1'b0, 1'b1, 3'b100},
      '{MODE_ALWAYS,     32'h1234_5678, 1'b1, 1'b1, 3'b110},
      '{MODE_ALWAYS,     32'hFFFF_FFFF, 1'b0, 1'b1, 3'b100},
      '{MODE_LOCAL,      32'h0000_0010, 1'b0, 1'b0, 3'b000},
      '{MODE_LOCAL,      32'h0000_0010, 1'b0, 1'b0, 3'b000},
      '{MODE_LOCAL,      32'h0000_0010, 1'b0, 1'b0, 3'b000},
      '{MODE_LOCAL,      32'h0000_0010, 1'b1, 1'b0, 3'b000},
      '{MODE_LOCAL,      32'hFFFF_FFFF, 1'b1, 1'b0, 3'b000},
      '{MODE_GSHARE,     32'h0000_0000, 1'b0, 1'b0, 3'b000},
      '{MODE_GSHARE,     32'h0000_0000, 1'b0, 1'b0, 3'b000},
      '{MODE_GSHARE,     32'h0000_03FF, 1'b1, 1'b0, 3'b000},
      '{MODE_GSHARE,     32'hFFFF_FFFF, 1'b0, 1'b0, 3'b000},
      '{MODE_TOURNAMENT, 32'h0000_0010, 1'b0, 1'b0, 3'b000},
      '{MODE_TOURNAMENT, 32'h0000_0010, 1'b0, 1'b0, 3'b000},
      '{MODE_TOURNAMENT, 32'h0000_0010, 1'b1, 1'b0, 3'b000},
      '{MODE_TOURNAMENT, 32'h0000_0000, 1'b1, 1'b0, 3'b000},
      '{MODE_TOURNAMENT, 32'h0000_02AA, 1'b0, 1'b0, 3'b000}
   };

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_wr_en;
   logic [1:0] csr_wr_data;

   tbp_req_if req_if ();
   tbp_rsp_if rsp_if ();

   tournament_branch_predictor dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_chan    (req_if),
      .rsp_chan    (rsp_if)
   );

   always #5 clock = ~clock;

   // Shadow predictor state
   logic [LHIST_W-1:0] hist_tbl    [TABLE_ENTRIES_DEF];
   logic [CTR_W-1:0]   local_ctr   [LOCAL_CTRS];
   logic [CTR_W-1:0]   gshare_ctr  [TABLE_ENTRIES_DEF];
   logic [CTR_W-1:0]   chooser_ctr [TABLE_ENTRIES_DEF];
   logic [GHIST_W-1:0] ghist;
   mode_type           cur_mode;

   verdict_type    predicted_q [$];
   branch_row_type answer_q [$];
   int             items_sent   = 0;
   int             results_seen = 0;
   int             fail_count   = 0;
   int             idle_cycles  = 0;
   int             calm_left [2] = '{0, 0};

   function automatic logic [CTR_W-1:0] bump_ctr(input logic [CTR_W-1:0] c, input logic up);
      if (up) return (c == CTR_MAX) ? c : c + CTR_W'(1);
      return (c == CTR_MIN) ? c : c - CTR_W'(1);
   endfunction

   // Predict from pre-training state, then train as the current mode dictates
   function automatic verdict_type predict_branch(input logic [PC_W-1:0] pc, input logic taken);
      logic [ENTRY_W-1:0]         slot;
      logic [ENTRY_W-1:0]         gslot;
      logic [LHIST_W-1:0]         lhist;
      logic [ENTRY_W+LHIST_W-1:0] lslot;
      logic                       lguess;
      logic                       gguess;
      logic                       teach_local;
      logic                       teach_gshare;
      verdict_type                v;
      slot         = ENTRY_W'(pc % TABLE_ENTRIES_DEF);
      lhist        = hist_tbl[slot];
      lslot        = {slot, lhist};
      gslot        = ENTRY_W'((pc ^ PC_W'(ghist)) % TABLE_ENTRIES_DEF);
      lguess       = local_ctr[lslot] >= CTR_TAKEN_MIN;
      gguess       = gshare_ctr[gslot] >= CTR_TAKEN_MIN;
      teach_local  = 1'b0;
      teach_gshare = 1'b0;
      case (cur_mode)
         MODE_ALWAYS: begin
            v.predicted_taken = 1'b1;
            v.used_global     = 1'b0;
         end
         MODE_LOCAL: begin
            v.predicted_taken = lguess;
            v.used_global     = 1'b0;
            teach_local       = 1'b1;
         end
         MODE_GSHARE: begin
            v.predicted_taken = gguess;
            v.used_global     = 1'b1;
            teach_gshare      = 1'b1;
         end
         default: begin
            v.used_global     = chooser_ctr[slot] >= CTR_TAKEN_MIN;
            v.predicted_taken = v.used_global ? gguess : lguess;
            teach_local       = 1'b1;
            teach_gshare      = 1'b1;
            // chooser leans toward whichever side alone got it right
            if ((lguess == taken) != (gguess == taken))
               chooser_ctr[slot] = bump_ctr(chooser_ctr[slot], gguess == taken);
         end
      endcase
      if (teach_local) begin
         local_ctr[lslot] = bump_ctr(local_ctr[lslot], taken);
         hist_tbl[slot]   = {lhist[LHIST_W-2:0], taken};
      end
      if (teach_gshare) begin
         gshare_ctr[gslot] = bump_ctr(gshare_ctr[gslot], taken);
         ghist             = {ghist[GHIST_W-2:0], taken};
      end
      v.prediction_correct = v.predicted_taken == taken;
      return v;
   endfunction

   // Idle gap per transfer, with occasional back-to-back runs
   function automatic int draw_gap(input int side);
      if (calm_left[side] > 0) begin
         calm_left[side]--;
         return 0;
      end
      if ($urandom_range(0, 39) == 0) calm_left[side] = $urandom_range(10, 40);
      return $urandom_range(0, 8);
   endfunction

   task automatic send_branch(input branch_row_type row);
      int gap;
      gap = draw_gap(SENDER);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      answer_q.push_back(row);
      req_if.valid        <= 1'b1;
      req_if.branch_pc    <= row.pc;
      req_if.branch_taken <= row.taken;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
   endtask

   // Mode writes only once every outstanding branch has come back
   task automatic change_mode(input mode_type m);
      req_if.valid <= 1'b0;
      while (results_seen < items_sent) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cur_mode = m;
   endtask

   // Response side: random stalls plus one long hold-off to back up the input
   initial begin : receiver
      int gap;
      bit held;
      held = 1'b0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      gap = draw_gap(RECEIVER);
      forever begin
         if (gap > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_if.valid) @(posedge clock);
         if (!held && results_seen >= HOLD_AT) begin
            held = 1'b1;
            gap  = HOLD_CYCLES;
         end else begin
            gap = draw_gap(RECEIVER);
         end
      end
   end

   // Compare each response transfer, then queue the prediction for each request transfer
   always @(posedge clock) begin : check_predictions
      verdict_type    want;
      verdict_type    seen;
      branch_row_type src;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            results_seen++;
            seen = '{rsp_if.predicted_taken, rsp_if.prediction_correct, rsp_if.used_global};
            if (predicted_q.size() == 0) begin
               $error("prediction transfer with no branch outstanding");
               fail_count++;
            end else begin
               want = predicted_q.pop_front();
               if (seen.predicted_taken !== want.predicted_taken) begin
                  $error("predicted_taken: expected %0b, got %0b",
                         want.predicted_taken, seen.predicted_taken);
                  fail_count++;
               end
               if (seen.prediction_correct !== want.prediction_correct) begin
                  $error("prediction_correct: expected %0b, got %0b",
                         want.prediction_correct, seen.prediction_correct);
                  fail_count++;
               end
               if (seen.used_global !== want.used_global) begin
                  $error("used_global: expected %0b, got %0b",
                         want.used_global, seen.used_global);
                  fail_count++;
               end
            end
         end
         if (req_if.valid && req_if.ready) begin
            want = predict_branch(req_if.branch_pc, req_if.branch_taken);
            if (answer_q.size() != 0) begin
               src = answer_q.pop_front();
               if (src.has_answer) want = src.answer;
            end
            predicted_q.push_back(want);
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      branch_row_type  row;
      logic [PC_W-1:0] pool_pc [POOL_SIZE];
      int              pool_period [POOL_SIZE];
      int              pool_trip [POOL_SIZE];
      int              sent_random;
      int              phase_len;
      int              k;
      reset               <= 1'b1;
      csr_wr_en           <= 1'b0;
      csr_wr_data         <= '0;
      req_if.valid        <= 1'b0;
      req_if.branch_pc    <= '0;
      req_if.branch_taken <= 1'b0;

      // shadow state matches the post-reset tables
      cur_mode = MODE_RESET;
      ghist    = '0;
      for (int i = 0; i < TABLE_ENTRIES_DEF; i++) begin
         hist_tbl[i]    = '0;
         gshare_ctr[i]  = CTR_RESET;
         chooser_ctr[i] = CTR_RESET;
      end
      for (int i = 0; i < LOCAL_CTRS; i++) local_ctr[i] = CTR_RESET;

      // branch pool: loop-like patterns, upper third aliases lower entries
      for (int i = 0; i < POOL_SIZE; i++) begin
         pool_pc[i] = $urandom();
         if (i >= 8) pool_pc[i][ENTRY_W-1:0] = pool_pc[i-8][ENTRY_W-1:0];
         pool_period[i] = $urandom_range(1, 9);
         pool_trip[i]   = 0;
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].mode != cur_mode) change_mode(DIRECTED[i].mode);
         send_branch(DIRECTED[i]);
      end

      // random phases, each under one mode
      sent_random = 0;
      while (sent_random < RANDOM_ITEMS) begin
         change_mode(mode_type'($urandom_range(0, 3)));
         phase_len = $urandom_range(150, 250);
         repeat (phase_len) begin
            if ($urandom_range(0, 4) != 0) begin
               k         = $urandom_range(0, POOL_SIZE - 1);
               row.pc    = pool_pc[k];
               row.taken = (pool_trip[k] % pool_period[k]) != pool_period[k] - 1;
               if ($urandom_range(0, 19) == 0) row.taken = !row.taken;
               pool_trip[k]++;
            end else begin
               row.pc    = $urandom();
               row.taken = $urandom_range(0, 1);
            end
            row.mode       = cur_mode;
            row.has_answer = 1'b0;
            row.answer     = '0;
            send_branch(row);
            sent_random++;
         end
      end

      req_if.valid <= 1'b0;
      while (results_seen < items_sent) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (predicted_q.size() != 0) begin
         $error("%0d predictions never returned", predicted_q.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/tbp_pkg.sv
rtl/tbp_if.sv
rtl/tbp_index_unit.sv
rtl/tbp_tables.sv
rtl/tbp_train.sv
rtl/tournament_branch_predictor.sv
verif/tournament_branch_predictor_test.sv
